// File: sv/sat_pkg.sv
package sat_pkg;

    localparam int SUM_W            = 44;
    localparam int VALUE_W          = 32;
    localparam int COORD_W          = 7;
    localparam int CFG_W            = 7;
    localparam int CFG_IDX_W        = 1;
    localparam int MAX_DIM_DEF      = 64;
    localparam int ELEMENT_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic       in_ready;
        logic       load_sum;
        logic       ld_rd;
        logic       ld_wr;
        logic       q_rd;
        logic       q_clear;
        logic [1:0] q_step;
        logic       acc_en;
        logic       out_load;
    } sat_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_query;
        logic bad;
        logic out_free;
    } sat_status_t;

endpackage

// File: sv/sat_in_if.sv
interface sat_in_if
    import sat_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        first_row;
    logic [COORD_W-1:0]        first_col;
    logic [COORD_W-1:0]        end_row;
    logic [COORD_W-1:0]        end_col;

    modport source (
        output valid, command, value, first_row, first_col, end_row, end_col,
        input  ready
    );

    modport sink (
        input  valid, command, value, first_row, first_col, end_row, end_col,
        output ready
    );
endinterface

// File: sv/sat_out_if.sv
interface sat_out_if
    import sat_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] rect_sum;
    logic                    error;

    modport source (
        output valid, rect_sum, error,
        input  ready
    );

    modport sink (
        input  valid, rect_sum, error,
        output ready
    );
endinterface

// File: sv/summed_area_table_query.sv
// Load item: one table read, then one write, before the next item can be accepted.
// Query item: four reads in turn on the single-port table memory (none on an error),
// then the result is registered and held until taken.
// Reset: rows and columns back to MAX_DIM, load position and row sum cleared, table not ready.
// Table contents are not cleared; a query reads only entries of a completed load.
module summed_area_table_query
    import sat_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sat_in_if.sink               in_chan,
    sat_out_if.source            out_chan
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;

    sat_cmd_t          cmd;
    sat_status_t       sts;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [SUM_W-1:0]  ram_wdata;
    logic [SUM_W-1:0]  ram_rdata;

    sat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    sat_datapath #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS),
        .IDX_W        (IDX_W),
        .ADDR_W       (ADDR_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_chan.valid),
        .in_command   (in_chan.command),
        .in_value     (in_chan.value),
        .in_first_row (in_chan.first_row),
        .in_first_col (in_chan.first_col),
        .in_end_row   (in_chan.end_row),
        .in_end_col   (in_chan.end_col),
        .out_ready    (out_chan.ready),
        .out_valid    (out_chan.valid),
        .out_rect_sum (out_chan.rect_sum),
        .out_error    (out_chan.error),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata)
    );

    sat_ram #(
        .WIDTH (SUM_W),
        .DEPTH (1 << ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_chan.ready = cmd.in_ready;

endmodule

// File: sv/sat_ram.sv
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/sat_ctrl.sv
module sat_ctrl
    import sat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sat_status_t sts,
    output sat_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LD_RD  = 3'd1;
    localparam logic [2:0] ST_LD_WR  = 3'd2;
    localparam logic [2:0] ST_Q_RD   = 3'd3;
    localparam logic [2:0] ST_Q_LAST = 3'd4;
    localparam logic [2:0] ST_Q_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.q_step = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                step_next    = 2'd0;
                if (sts.in_fire)
                begin
                    state_next = sts.in_query ? ST_Q_RD : ST_LD_RD;
                end
            end
            ST_LD_RD:
            begin
                cmd.load_sum = 1'b1;
                cmd.ld_rd    = 1'b1;
                state_next   = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                cmd.ld_wr  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_Q_RD:
            begin
                if (step_reg == 2'd0 && sts.bad)
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    cmd.q_rd    = 1'b1;
                    cmd.q_clear = (step_reg == 2'd0);
                    cmd.acc_en  = (step_reg != 2'd0);
                    step_next   = step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        state_next = ST_Q_LAST;
                    end
                end
            end
            ST_Q_LAST:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: sv/sat_datapath.sv
module sat_datapath
    import sat_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
    parameter int IDX_W        = $clog2(MAX_DIM),
    parameter int ADDR_W       = 2 * IDX_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sat_cmd_t                  cmd,
    output sat_status_t               sts,
    input  logic                      cfg_write_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    input  logic                      in_command,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic [COORD_W-1:0]        in_first_row,
    input  logic [COORD_W-1:0]        in_first_col,
    input  logic [COORD_W-1:0]        in_end_row,
    input  logic [COORD_W-1:0]        in_end_col,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [SUM_W-1:0]   out_rect_sum,
    output logic                      out_error,
    output logic                      ram_we,
    output logic [ADDR_W-1:0]         ram_addr,
    output logic [SUM_W-1:0]          ram_wdata,
    input  logic [SUM_W-1:0]          ram_rdata
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0]   num_rows_reg;
    logic [DIM_W-1:0]   num_cols_reg;
    logic [IDX_W-1:0]   load_row_reg;
    logic [IDX_W-1:0]   load_col_reg;
    logic [SUM_W-1:0]   rsum_reg;
    logic               ready_reg;
    logic [SUM_W-1:0]   elem_reg;
    logic [COORD_W-1:0] sr_reg;
    logic [COORD_W-1:0] sc_reg;
    logic [COORD_W-1:0] er_reg;
    logic [COORD_W-1:0] ec_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [SUM_W-1:0]   acc_next;
    logic               pend_zero_reg;
    logic               pend_neg_reg;
    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic               out_error_reg;

    logic [DIM_W-1:0]   cfg_clamped;
    logic               in_fire;
    logic               col_last;
    logic               row_last;
    logic               bad;
    logic [IDX_W-1:0]   er_i;
    logic [IDX_W-1:0]   ec_i;
    logic [IDX_W-1:0]   sr_i;
    logic [IDX_W-1:0]   sc_i;
    logic [IDX_W-1:0]   term_row;
    logic [IDX_W-1:0]   term_col;
    logic               term_zero;
    logic               term_neg;
    logic [SUM_W-1:0]   term_val;

    assign in_fire = in_valid && cmd.in_ready;

    assign cfg_clamped = (cfg_data == '0)     ? DIM_W'(1) :
                         (cfg_data > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_data);

    assign col_last = (DIM_W'(load_col_reg) + DIM_W'(1)) >= num_cols_reg;
    assign row_last = (DIM_W'(load_row_reg) + DIM_W'(1)) >= num_rows_reg;

    assign bad = !ready_reg || sr_reg == '0 || sc_reg == '0 || sr_reg > er_reg ||
                 sc_reg > ec_reg || er_reg > num_rows_reg || ec_reg > num_cols_reg;

    // 0-based indices; the start terms sit one row or column before the start
    assign er_i = IDX_W'(er_reg - COORD_W'(1));
    assign ec_i = IDX_W'(ec_reg - COORD_W'(1));
    assign sr_i = IDX_W'(sr_reg - COORD_W'(2));
    assign sc_i = IDX_W'(sc_reg - COORD_W'(2));

    always_comb
    begin
        term_row  = er_i;
        term_col  = ec_i;
        term_zero = 1'b0;
        term_neg  = 1'b0;
        case (cmd.q_step)
            2'd0:
            begin
                term_row = er_i;
                term_col = ec_i;
            end
            2'd1:
            begin
                term_row  = sr_i;
                term_col  = ec_i;
                term_zero = (sr_reg == COORD_W'(1));
                term_neg  = 1'b1;
            end
            2'd2:
            begin
                term_row  = er_i;
                term_col  = sc_i;
                term_zero = (sc_reg == COORD_W'(1));
                term_neg  = 1'b1;
            end
            2'd3:
            begin
                term_row  = sr_i;
                term_col  = sc_i;
                term_zero = (sr_reg == COORD_W'(1)) || (sc_reg == COORD_W'(1));
            end
            default:
            begin
                term_zero = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = cmd.ld_wr;
        ram_wdata = ((load_row_reg == '0) ? '0 : ram_rdata) + rsum_reg;
        if (cmd.ld_rd)
        begin
            ram_addr = {load_row_reg - IDX_W'(1), load_col_reg};
        end
        else if (cmd.ld_wr)
        begin
            ram_addr = {load_row_reg, load_col_reg};
        end
        else
        begin
            ram_addr = {term_row, term_col};
        end
    end

    assign term_val = pend_zero_reg ? '0 : ram_rdata;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.q_clear)
        begin
            acc_next = '0;
        end
        else if (cmd.acc_en)
        begin
            acc_next = pend_neg_reg ? acc_reg - term_val : acc_reg + term_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            elem_reg <= SUM_W'(signed'(in_value[ELEMENT_BITS-1:0]));
            sr_reg   <= in_first_row;
            sc_reg   <= in_first_col;
            er_reg   <= in_end_row;
            ec_reg   <= in_end_col;
        end
        if (cmd.q_rd)
        begin
            pend_zero_reg <= term_zero;
            pend_neg_reg  <= term_neg;
        end
        acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            out_sum_reg   <= bad ? '0 : acc_reg;
            out_error_reg <= bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= DIM_W'(MAX_DIM);
            num_cols_reg  <= DIM_W'(MAX_DIM);
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            rsum_reg      <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_NUM_ROWS: num_rows_reg <= cfg_clamped;
                    CFG_NUM_COLS: num_cols_reg <= cfg_clamped;
                    default: ;
                endcase
                load_row_reg <= '0;
                load_col_reg <= '0;
                rsum_reg     <= '0;
                ready_reg    <= 1'b0;
            end
            else if (cmd.load_sum)
            begin
                // a new row starts its running sum afresh
                rsum_reg  <= ((load_col_reg == '0) ? '0 : rsum_reg) + elem_reg;
                ready_reg <= 1'b0;
            end
            else if (cmd.ld_wr)
            begin
                if (col_last)
                begin
                    load_col_reg <= '0;
                    if (row_last)
                    begin
                        load_row_reg <= '0;
                        ready_reg    <= 1'b1;
                    end
                    else
                    begin
                        load_row_reg <= load_row_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    load_col_reg <= load_col_reg + IDX_W'(1);
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_rect_sum = out_sum_reg;
    assign out_error    = out_error_reg;

    assign sts.in_fire  = in_fire;
    assign sts.in_query = (in_command == CMD_QUERY);
    assign sts.bad      = bad;
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule
